### rtl/core/dwsl_pkg.sv
// Shared types and constants for the differential drive wheel speed limiter.
`timescale 1ns / 1ps
`default_nettype none
package dwsl_pkg;
	localparam int SPEED_DIV = 2000;
	localparam int RATE_MUL = 1000;
	localparam int RECIP_SHIFT = 31;
	localparam logic [24:0] RECIP_125 = 25'd17179870;
	localparam int RATE_STEPS = 28;
	localparam int SCALE_STEPS = 16;

	localparam logic [1:0] REG_BASE = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [28:0] turn;
	} cmd_t;
endpackage
`default_nettype wire

### rtl/core/dwsl_if.sv
// Valid/ready channel interfaces for velocity commands and wheel rates.
`timescale 1ns / 1ps
`default_nettype none
interface dwsl_cmd_if;
	logic valid;
	logic ready;
	logic signed [15:0] forward_speed;
	logic signed [15:0] yaw_rate;
	modport source (output valid, forward_speed, yaw_rate, input ready);
	modport sink (input valid, forward_speed, yaw_rate, output ready);
endinterface

interface dwsl_rate_if;
	logic valid;
	logic ready;
	logic signed [16:0] left_wheel_rate;
	logic signed [16:0] right_wheel_rate;
	modport source (output valid, left_wheel_rate, right_wheel_rate, input ready);
	modport sink (input valid, left_wheel_rate, right_wheel_rate, output ready);
endinterface
`default_nettype wire

### rtl/core/dwsl_front.sv
// Command intake: register the forward speed and the turn term.
`timescale 1ns / 1ps
`default_nettype none
module dwsl_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	dwsl_cmd_if.sink             cmd,
	input  wire logic [11:0]     wheel_base,
	output dwsl_pkg::cmd_t       word,
	output logic                 word_valid,
	input  wire logic            word_ready
);
	logic           valid_q;
	dwsl_pkg::cmd_t word_q;

	assign cmd.ready = !valid_q || word_ready;
	assign word = word_q;
	assign word_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ready) begin
			valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			word_q.vx <= cmd.forward_speed;
			word_q.turn <= 29'(cmd.yaw_rate) * $signed({17'b0, wheel_base});
		end
	end
endmodule
`default_nettype wire

### rtl/core/dwsl_fifo.sv
// Two-entry queue between command intake and the rate pipeline.
`timescale 1ns / 1ps
`default_nettype none
module dwsl_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dwsl_pkg::cmd_t push_word,
	input  wire logic           push_valid,
	output logic                push_ready,
	output dwsl_pkg::cmd_t      pop_word,
	output logic                pop_valid,
	input  wire logic           pop_ready
);
	dwsl_pkg::cmd_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_word = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end
endmodule
`default_nettype wire

### rtl/core/dwsl_back.sv
// Rate pipeline: rim speeds, division by radius, proportional limiting.
`timescale 1ns / 1ps
`default_nettype none
module dwsl_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dwsl_pkg::cmd_t in_word,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [9:0]     wheel_radius,
	input  wire logic [15:0]    max_rate,
	dwsl_rate_if.source         rate
);
	localparam int D1 = dwsl_pkg::RATE_STEPS;
	localparam int D2 = dwsl_pkg::SCALE_STEPS;
	localparam int STAGES = 3 + D1 + 2 + D2 + 1;

	logic [STAGES-1:0] vld_q;
	logic              en;
	logic [9:0]        div_r;

	logic        sg_s1 [2];
	logic [23:0] x_s1 [2];
	logic        sg_s2 [2];
	logic [17:0] rim_s2 [2];
	logic        sg_s3 [2];
	logic [27:0] n_s3 [2];
	logic        sg_s4 [2][D1];
	logic [9:0]  rem_s4 [2][D1];
	logic [27:0] num_s4 [2][D1];
	logic        sg_s5 [2];
	logic [27:0] a_s5 [2];
	logic [27:0] mx_s5;
	logic        ov_s5;
	logic        sg_s6 [2];
	logic [43:0] p_s6 [2];
	logic [15:0] aq_s6 [2];
	logic [27:0] mx_s6;
	logic        ov_s6;
	logic        sg_s7 [2][D2];
	logic [27:0] rem_s7 [2][D2];
	logic [15:0] num_s7 [2][D2];
	logic [15:0] aq_s7 [2][D2];
	logic [27:0] mx_s7 [D2];
	logic        ov_s7 [D2];
	logic signed [16:0] left_s8;
	logic signed [16:0] right_s8;

	logic signed [29:0] spd;
	logic signed [29:0] sum [2];
	logic [29:0]        smag [2];
	logic [9:0]         rem1_nx [2][D1];
	logic [27:0]        num1_nx [2][D1];
	logic [27:0]        rem2_nx [2][D2];
	logic [15:0]        num2_nx [2][D2];
	logic [16:0]        mag17 [2];

	assign en = !vld_q[STAGES-1] || rate.ready;
	assign in_ready = en;
	assign rate.valid = vld_q[STAGES-1];
	assign rate.left_wheel_rate = left_s8;
	assign rate.right_wheel_rate = right_s8;
	assign div_r = (wheel_radius == 10'd0) ? 10'd1 : wheel_radius;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	always_comb begin
		logic [9:0]  r1;
		logic [27:0] n1;
		logic [10:0] t1;
		logic [27:0] r2;
		logic [15:0] n2;
		logic [28:0] t2;
		spd = 30'(in_word.vx) * 30'(dwsl_pkg::SPEED_DIV);
		sum[0] = spd - 30'(in_word.turn);
		sum[1] = spd + 30'(in_word.turn);
		for (int i = 0; i < 2; i++) begin
			smag[i] = sum[i][29] ? 30'(-sum[i]) : sum[i];
			for (int k = 0; k < D1; k++) begin
				r1 = (k == 0) ? 10'd0 : rem_s4[i][(k == 0) ? 0 : k - 1];
				n1 = (k == 0) ? n_s3[i] : num_s4[i][(k == 0) ? 0 : k - 1];
				t1 = {r1, n1[27]};
				if (t1 >= {1'b0, div_r}) begin
					rem1_nx[i][k] = 10'(t1 - {1'b0, div_r});
					num1_nx[i][k] = {n1[26:0], 1'b1};
				end else begin
					rem1_nx[i][k] = t1[9:0];
					num1_nx[i][k] = {n1[26:0], 1'b0};
				end
			end
			for (int k = 0; k < D2; k++) begin
				r2 = (k == 0) ? p_s6[i][43:16] : rem_s7[i][(k == 0) ? 0 : k - 1];
				n2 = (k == 0) ? p_s6[i][15:0] : num_s7[i][(k == 0) ? 0 : k - 1];
				t2 = {r2, n2[15]};
				if (t2 >= {1'b0, ((k == 0) ? mx_s6 : mx_s7[(k == 0) ? 0 : k - 1])}) begin
					rem2_nx[i][k] = 28'(t2 - {1'b0,
						((k == 0) ? mx_s6 : mx_s7[(k == 0) ? 0 : k - 1])});
					num2_nx[i][k] = {n2[14:0], 1'b1};
				end else begin
					rem2_nx[i][k] = t2[27:0];
					num2_nx[i][k] = {n2[14:0], 1'b0};
				end
			end
			mag17[i] = {1'b0, ov_s7[D2-1] ? num_s7[i][D2-1] : aq_s7[i][D2-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				sg_s1[i] <= sum[i][29];
				x_s1[i] <= smag[i][27:4];
				sg_s2[i] <= sg_s1[i];
				rim_s2[i] <= 18'((49'(x_s1[i]) * 49'(dwsl_pkg::RECIP_125))
					>> dwsl_pkg::RECIP_SHIFT);
				sg_s3[i] <= sg_s2[i];
				n_s3[i] <= 28'(rim_s2[i]) * 28'(dwsl_pkg::RATE_MUL);
				for (int k = 0; k < D1; k++) begin
					sg_s4[i][k] <= (k == 0) ? sg_s3[i] : sg_s4[i][(k == 0) ? 0 : k - 1];
					rem_s4[i][k] <= rem1_nx[i][k];
					num_s4[i][k] <= num1_nx[i][k];
				end
				sg_s5[i] <= sg_s4[i][D1-1];
				a_s5[i] <= num_s4[i][D1-1];
				sg_s6[i] <= sg_s5[i];
				p_s6[i] <= 44'(a_s5[i]) * 44'(max_rate);
				aq_s6[i] <= a_s5[i][15:0];
				for (int k = 0; k < D2; k++) begin
					sg_s7[i][k] <= (k == 0) ? sg_s6[i] : sg_s7[i][(k == 0) ? 0 : k - 1];
					aq_s7[i][k] <= (k == 0) ? aq_s6[i] : aq_s7[i][(k == 0) ? 0 : k - 1];
					rem_s7[i][k] <= rem2_nx[i][k];
					num_s7[i][k] <= num2_nx[i][k];
				end
			end
			mx_s5 <= (num_s4[0][D1-1] > num_s4[1][D1-1]) ? num_s4[0][D1-1]
				: num_s4[1][D1-1];
			ov_s5 <= ((num_s4[0][D1-1] > num_s4[1][D1-1]) ? num_s4[0][D1-1]
				: num_s4[1][D1-1]) > {12'b0, max_rate};
			mx_s6 <= mx_s5;
			ov_s6 <= ov_s5;
			for (int k = 0; k < D2; k++) begin
				mx_s7[k] <= (k == 0) ? mx_s6 : mx_s7[(k == 0) ? 0 : k - 1];
				ov_s7[k] <= (k == 0) ? ov_s6 : ov_s7[(k == 0) ? 0 : k - 1];
			end
			left_s8 <= sg_s7[0][D2-1] ? mag17[0] : 17'(-mag17[0]);
			right_s8 <= sg_s7[1][D2-1] ? 17'(-mag17[1]) : mag17[1];
		end
	end
endmodule
`default_nettype wire

### rtl/core/diff_drive_wheel_speed_limiter.sv
// Differential drive wheel speed limiter top level.
//
// cmd carries one body velocity command per word (forward speed, yaw rate);
// rate returns one word per command with the negated left and the right
// wheel rate, limited proportionally to the rate limit register.
// The cfg port writes wheel base, radius and rate limit; write only while
// no command is in flight.
// The 28-step divider by the radius and the 16-step scaling divider are
// fully pipelined, one quotient bit per stage, so one command is taken
// per cycle unless the pipeline holds for rate.ready.
// A two-word queue sits between intake and pipeline; when rate.ready is
// low the pipeline holds in place, the queue fills and cmd.ready drops.
// Reset empties intake, queue and pipeline and loads the registers with
// base 400 mm, radius 75 mm and limit 5000.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_wheel_speed_limiter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dwsl_cmd_if.sink         cmd,
	dwsl_rate_if.source      rate,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	logic [11:0]    base_q;
	logic [9:0]     radius_q;
	logic [15:0]    limit_q;
	dwsl_pkg::cmd_t f_word;
	logic           f_valid;
	logic           f_ready;
	dwsl_pkg::cmd_t q_word;
	logic           q_valid;
	logic           q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 12'd400;
			radius_q <= 10'd75;
			limit_q <= 16'd5000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dwsl_pkg::REG_BASE: base_q <= cfg_wdata[11:0];
				dwsl_pkg::REG_RADIUS: radius_q <= cfg_wdata[9:0];
				dwsl_pkg::REG_LIMIT: limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dwsl_front u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .wheel_base(base_q),
		.word(f_word), .word_valid(f_valid), .word_ready(f_ready)
	);

	dwsl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_word(f_word), .push_valid(f_valid), .push_ready(f_ready),
		.pop_word(q_word), .pop_valid(q_valid), .pop_ready(q_ready)
	);

	dwsl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_word(q_word), .in_valid(q_valid), .in_ready(q_ready),
		.wheel_radius(radius_q), .max_rate(limit_q), .rate(rate)
	);

	a_radius_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == dwsl_pkg::REG_RADIUS |=> radius_q == $past(cfg_wdata[9:0]))
		else $error("radius register not written");
	a_limit_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == dwsl_pkg::REG_LIMIT |=> limit_q == $past(cfg_wdata))
		else $error("limit register not written");
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rate.valid)
		else $error("result word present out of reset");
endmodule
`default_nettype wire

### sim/dwsl_checker.sv
// Checker for the wheel speed limiter: predicts wheel rates and compares each result word.
`timescale 1ns / 1ps
module dwsl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	dwsl_cmd_if.sink        cmd,
	dwsl_rate_if.sink       rate,
	input wire logic        cfg_we,
	input wire logic [1:0]  cfg_index,
	input wire logic [15:0] cfg_wdata,
	output int              fail_count,
	output int              pending
);
	typedef struct {
		logic signed [16:0] left;
		logic signed [16:0] right;
	} wheel_rates_t;

	logic [11:0] base_mm;
	logic [9:0]  radius_mm;
	logic [15:0] rate_limit;
	wheel_rates_t expected_rates[$];

	function automatic wheel_rates_t wheel_rates(logic signed [15:0] vx,
			logic signed [15:0] wz);
		longint turn, radius, limit, rim_l, rim_r, pl, pr, al, ar, mx;
		wheel_rates_t r;
		turn = longint'(wz) * longint'(base_mm);
		radius = (radius_mm == 0) ? 1 : longint'(radius_mm);
		limit = longint'(rate_limit);
		rim_l = (longint'(vx) * dwsl_pkg::SPEED_DIV - turn) / dwsl_pkg::SPEED_DIV;
		rim_r = (longint'(vx) * dwsl_pkg::SPEED_DIV + turn) / dwsl_pkg::SPEED_DIV;
		pl = (rim_l * dwsl_pkg::RATE_MUL) / radius;
		pr = (rim_r * dwsl_pkg::RATE_MUL) / radius;
		al = pl < 0 ? -pl : pl;
		ar = pr < 0 ? -pr : pr;
		mx = al > ar ? al : ar;
		if (mx > limit) begin
			pl = (pl * limit) / mx;
			pr = (pr * limit) / mx;
		end
		r.left = 17'(-pl);
		r.right = 17'(pr);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wheel_rates_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			base_mm <= 12'd400;
			radius_mm <= 10'd75;
			rate_limit <= 16'd5000;
			fail_count <= 0;
			pending <= 0;
			expected_rates.delete();
		end else begin
			if (cmd.valid && cmd.ready)
				expected_rates.push_back(wheel_rates(cmd.forward_speed, cmd.yaw_rate));
			if (rate.valid && rate.ready) begin
				if (expected_rates.size() == 0) begin
					$display("%0t: unexpected word left=%0d right=%0d", $time,
						rate.left_wheel_rate, rate.right_wheel_rate);
					errs = errs + 1;
				end else begin
					e = expected_rates.pop_front();
					if (rate.left_wheel_rate !== e.left) begin
						$display("%0t: left rate expected %0d actual %0d", $time,
							e.left, rate.left_wheel_rate);
						errs = errs + 1;
					end
					if (rate.right_wheel_rate !== e.right) begin
						$display("%0t: right rate expected %0d actual %0d", $time,
							e.right, rate.right_wheel_rate);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= expected_rates.size();
			if (cfg_we) begin
				case (cfg_index)
					dwsl_pkg::REG_BASE: base_mm <= cfg_wdata[11:0];
					dwsl_pkg::REG_RADIUS: radius_mm <= cfg_wdata[9:0];
					dwsl_pkg::REG_LIMIT: rate_limit <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end
endmodule

### sim/tb_diff_drive_wheel_speed_limiter.sv
// Top of the wheel speed limiter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_diff_drive_wheel_speed_limiter;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        calm;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	bit          timed_out;

	dwsl_cmd_if  cmd ();
	dwsl_rate_if rate ();

	diff_drive_wheel_speed_limiter i_dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .rate(rate.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	dwsl_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .rate(rate.sink),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		rate.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rate.ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rate.valid && rate.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_command(logic [15:0] vx, logic [15:0] wz);
		while (!calm && $urandom_range(99) < 22) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.forward_speed <= vx;
		cmd.yaw_rate <= wz;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0 && !timed_out) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_speed();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(200)) - 100);
			3: return 16'(int'($urandom_range(4000)) - 2000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic configure(logic [15:0] b, logic [15:0] r, logic [15:0] l);
		write_reg(dwsl_pkg::REG_BASE, b);
		write_reg(dwsl_pkg::REG_RADIUS, r);
		write_reg(dwsl_pkg::REG_LIMIT, l);
	endtask

	task automatic random_phase(int count);
		repeat (count) send_command(pick_speed(), pick_speed());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dwsl_pkg::REG_BASE;
		cfg_wdata = '0;
		cmd.valid = 1'b0;
		cmd.forward_speed = '0;
		cmd.yaw_rate = '0;
		calm = 1'b0;
		timed_out = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_command(16'h0000, 16'h0000);
		send_command(16'h7fff, 16'h0000);
		send_command(16'h8000, 16'h0000);
		send_command(16'h0000, 16'h7fff);
		send_command(16'h0000, 16'h8000);
		send_command(16'h7fff, 16'h7fff);
		send_command(16'h8000, 16'h8000);
		send_command(16'h7fff, 16'h8000);
		send_command(16'h0064, 16'hff9c);
		send_command(16'hffff, 16'h0001);
		drain();
		write_reg(REG_UNUSED, 16'hffff);
		configure(16'h0000, 16'h0000, 16'h0000);
		send_command(16'h0010, 16'h0005);
		send_command(16'h8000, 16'h7fff);
		send_command(16'h0000, 16'h0000);
		drain();
		configure(16'hffff, 16'h0001, 16'hffff);
		send_command(16'h7fff, 16'h8000);
		send_command(16'h8000, 16'h7fff);
		send_command(16'h0001, 16'h0001);
		drain();
		configure(16'h0fff, 16'h03ff, 16'h0001);
		send_command(16'h7fff, 16'h7fff);
		send_command(16'h0400, 16'hfc00);
		drain();

		random_phase(250);
		calm = 1'b1;
		random_phase(250);
		calm = 1'b0;
		repeat (5) begin
			configure(16'($urandom_range(4095)), 16'($urandom_range(1023)),
				16'($urandom));
			random_phase(150);
		end
		configure(16'd400, 16'd75, 16'd5000);
		random_phase(250);

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end
endmodule

### sim.f
rtl/core/dwsl_pkg.sv
rtl/core/dwsl_if.sv
rtl/core/dwsl_front.sv
rtl/core/dwsl_fifo.sv
rtl/core/dwsl_back.sv
rtl/core/diff_drive_wheel_speed_limiter.sv
sim/dwsl_checker.sv
sim/tb_diff_drive_wheel_speed_limiter.sv
